FILE: design/slip_frame_decoder_fcs16_macros.svh
// Assertion macros shared by the SLIP frame decoder modules.
// The macros expect signals named clk and arst_n in the scope where they are used.
`ifndef SLIP_FRAME_DECODER_FCS16_MACROS_SVH
`define SLIP_FRAME_DECODER_FCS16_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SFD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/sfd_pkg.sv
// Package for the SLIP frame decoder: framing codes, FCS constants, token and result types.
// Has no dependencies; used by every module of the block but sfd_fifo.
`timescale 1ns / 1ps

package sfd_pkg;

	localparam logic [7:0] SLIP_END  = 8'hC0;
	localparam logic [7:0] SLIP_ESC  = 8'hDB;
	localparam logic [7:0] SLIP_TEND = 8'hDC;
	localparam logic [7:0] SLIP_TESC = 8'hDD;

	localparam logic [15:0] FCS_INIT = 16'hFFFF;
	localparam logic [15:0] FCS_GOOD = 16'hF0B8;
	localparam logic [15:0] FCS_POLY = 16'h8408;

	localparam int LEN_W   = 12;
	localparam int LEN_SAT = 4095;

	localparam int DEFAULT_MAX_FRAME_BYTES = 2048;
	localparam int DEFAULT_QUEUE_DEPTH     = 2;

	// Register word addresses on the configuration port.
	localparam logic REG_FCS_DISABLED = 1'b0;

	typedef enum logic [1:0] {
		TOK_DATA   = 2'd0,
		TOK_END    = 2'd1,
		TOK_BADESC = 2'd2
	} tok_kind_t;

	typedef enum logic [1:0] {
		ST_GOOD     = 2'd0,
		ST_BADESC   = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_FCS      = 2'd3
	} frame_status_t;

	typedef struct packed {
		tok_kind_t  kind;
		logic [7:0] value;
	} tok_t;

	typedef struct packed {
		logic [7:0]       data_byte;
		logic             frame_last;
		frame_status_t    frame_status;
		logic [LEN_W-1:0] frame_length;
	} res_t;

	// One byte of the reflected CCITT FCS, bit at a time.
	function automatic logic [15:0] fcs16_update(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] a;
		a = acc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (a[0]) begin
				a = (a >> 1) ^ FCS_POLY;
			end else begin
				a = a >> 1;
			end
		end
		return a;
	endfunction

endpackage

FILE: design/sfd_fifo.sv
// Small register queue used between the decoder stages and on the result side.
// Generic width and depth; takes the shared assertion macros.
`timescale 1ns / 1ps
`include "slip_frame_decoder_fcs16_macros.svh"

module sfd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	`SFD_ASSERT_IMP(a_fifo_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

FILE: design/sfd_front.sv
// Front stage of the SLIP frame decoder: removes escapes and classifies each line byte.
// Depends on sfd_pkg for the framing codes and the token type.
`timescale 1ns / 1ps

module sfd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    line_byte,
	output logic          tok_valid,
	output sfd_pkg::tok_t tok
);

	import sfd_pkg::*;

	logic escape_q;

	always_comb begin
		tok_valid  = 1'b0;
		tok.kind   = TOK_DATA;
		tok.value  = line_byte;
		if (accept) begin
			if (escape_q) begin
				tok_valid = 1'b1;
				if (line_byte == SLIP_TESC) begin
					tok.value = SLIP_ESC;
				end else if (line_byte == SLIP_TEND) begin
					tok.value = SLIP_END;
				end else begin
					tok.kind = TOK_BADESC;
				end
			end else if (line_byte == SLIP_END) begin
				tok_valid = 1'b1;
				tok.kind  = TOK_END;
			end else if (line_byte != SLIP_ESC) begin
				tok_valid = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q <= 1'b0;
		end else if (accept) begin
			escape_q <= !escape_q && (line_byte == SLIP_ESC);
		end
	end

endmodule

FILE: design/sfd_back.sv
// Back stage of the SLIP frame decoder: frame length, overflow, FCS check and byte hold-back.
// Depends on sfd_pkg; takes the shared assertion macros.
`timescale 1ns / 1ps
`include "slip_frame_decoder_fcs16_macros.svh"

module sfd_back #(
	parameter int MAX_FRAME_BYTES = sfd_pkg::DEFAULT_MAX_FRAME_BYTES
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fcs_disabled,
	input  logic          tok_valid,
	input  sfd_pkg::tok_t tok,
	output logic          tok_pop,
	input  logic          res_full,
	output logic          res_push,
	output sfd_pkg::res_t res
);

	import sfd_pkg::*;

	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int SAT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

	logic [CNT_W-1:0] byte_count_q, byte_count_n;
	logic             overflow_q, overflow_n;
	logic [15:0]      fcs_q, fcs_n;
	logic [1:0]       held_count_q, held_count_n;
	logic [7:0]       held0_q, held1_q;
	logic             hold_wr;
	logic             hold_shift;
	logic             do_end;
	frame_status_t    end_status;
	logic [CNT_W-1:0] emitted;
	logic [CNT_W-1:0] len_raw;
	logic [SAT_W-1:0] len_ext;

	assign tok_pop = tok_valid && !res_full;
	assign emitted = byte_count_q - CNT_W'(held_count_q);
	assign len_ext = SAT_W'(len_raw);

	always_comb begin
		byte_count_n = byte_count_q;
		overflow_n   = overflow_q;
		fcs_n        = fcs_q;
		held_count_n = held_count_q;
		hold_wr      = 1'b0;
		hold_shift   = 1'b0;
		do_end       = 1'b0;
		end_status   = ST_GOOD;
		len_raw      = emitted;
		res_push     = 1'b0;
		res          = '0;
		if (tok_pop) begin
			unique case (tok.kind)
				TOK_DATA: begin
					if (byte_count_q == CNT_W'(MAX_FRAME_BYTES)) begin
						overflow_n = 1'b1;
					end else begin
						byte_count_n = byte_count_q + 1'b1;
						fcs_n        = fcs16_update(fcs_q, tok.value);
						if (fcs_disabled) begin
							res_push      = 1'b1;
							res.data_byte = tok.value;
						end else if (held_count_q != 2'd2) begin
							hold_wr      = 1'b1;
							held_count_n = held_count_q + 1'b1;
						end else begin
							hold_shift    = 1'b1;
							res_push      = 1'b1;
							res.data_byte = held0_q;
						end
					end
				end
				TOK_END: begin
					if (byte_count_q != '0) begin
						do_end = 1'b1;
						priority if (overflow_q) begin
							end_status = ST_OVERFLOW;
						end else if (!fcs_disabled
							&& (byte_count_q < CNT_W'(3) || fcs_q != FCS_GOOD)) begin
							end_status = ST_FCS;
						end else if (!fcs_disabled) begin
							len_raw = byte_count_q - CNT_W'(2);
						end else begin
							end_status = ST_GOOD;
						end
					end
				end
				TOK_BADESC: begin
					do_end     = 1'b1;
					end_status = ST_BADESC;
				end
				default: begin
				end
			endcase
		end
		if (do_end) begin
			res_push         = 1'b1;
			res.frame_last   = 1'b1;
			res.frame_status = end_status;
			res.frame_length = (len_ext > SAT_W'(LEN_SAT)) ? LEN_W'(LEN_SAT)
				: LEN_W'(len_ext);
			byte_count_n     = '0;
			overflow_n       = 1'b0;
			fcs_n            = FCS_INIT;
			held_count_n     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			overflow_q   <= 1'b0;
			fcs_q        <= FCS_INIT;
			held_count_q <= '0;
		end else begin
			byte_count_q <= byte_count_n;
			overflow_q   <= overflow_n;
			fcs_q        <= fcs_n;
			held_count_q <= held_count_n;
		end
	end

	always_ff @(posedge clk) begin
		if (hold_wr) begin
			if (held_count_q[0]) begin
				held1_q <= tok.value;
			end else begin
				held0_q <= tok.value;
			end
		end else if (hold_shift) begin
			held0_q <= held1_q;
			held1_q <= tok.value;
		end
	end

	`SFD_ASSERT_IMP(a_held_bound, 1'b1, held_count_q <= 2'd2, "more than two bytes held back")
	`SFD_ASSERT_IMP(a_overflow_at_max, overflow_q, byte_count_q == CNT_W'(MAX_FRAME_BYTES), "overflow flagged below the length limit")
	`SFD_ASSERT_NEXT(a_end_clears, res_push && res.frame_last, byte_count_q == '0 && held_count_q == '0 && !overflow_q, "frame state not cleared after end item")

endmodule

FILE: design/slip_frame_decoder_fcs16.sv
// Top level of the SLIP receive deframer with optional 16-bit FCS check and strip.
// Depends on sfd_pkg, sfd_front, sfd_fifo and sfd_back.
//
// Channel     | Handshake                        | Payload
// ------------+----------------------------------+------------------------------------------
// line in     | push / full                      | line_byte
// result out  | pop / empty                      | data_byte, frame_last, frame_status,
//             |                                  | frame_length
// config      | psel, penable, pwrite, pready=1  | paddr, pwdata, prdata
//
// One line byte is taken per cycle while the token queue has room. A byte that produces
// a result passes through the token queue and then the result queue before it can be
// popped. The frame engine handles one token per cycle while the result queue has room,
// its FCS update being the longest path. Reset clears all frame state and sets
// fcs_disabled; no clearing pass is needed. When the result queue fills, the engine
// stalls, the token queue fills in turn and full rises; nothing is lost.
`timescale 1ns / 1ps

module slip_frame_decoder_fcs16 #(
	parameter int MAX_FRAME_BYTES = sfd_pkg::DEFAULT_MAX_FRAME_BYTES,
	parameter int QUEUE_DEPTH     = sfd_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// line byte side
	input  logic                     push,
	output logic                     full,
	input  logic [7:0]               line_byte,
	// result side
	output logic                     empty,
	input  logic                     pop,
	output logic [7:0]               data_byte,
	output logic                     frame_last,
	output logic [1:0]               frame_status,
	output logic [sfd_pkg::LEN_W-1:0] frame_length,
	// configuration port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [2:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	import sfd_pkg::*;

	logic fcs_disabled_q;
	logic accept;
	logic fr_tok_valid;
	tok_t fr_tok;
	logic mid_full;
	logic mid_empty;
	tok_t mid_tok;
	logic bk_tok_pop;
	logic out_full;
	logic bk_res_push;
	res_t bk_res;
	res_t out_res;

	// A beat enters whenever the token queue has room; escapes produce no token.
	assign full   = mid_full;
	assign accept = push && !mid_full;

	// Configuration: one register, fcs_disabled, at byte address zero. The low two
	// address bits are ignored, so every address maps onto a word.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FCS_DISABLED) ? {31'b0, fcs_disabled_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcs_disabled_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_FCS_DISABLED) begin
			fcs_disabled_q <= pwdata[0];
		end
	end

	// Front: unescape and classify.
	sfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.line_byte (line_byte),
		.tok_valid (fr_tok_valid),
		.tok       (fr_tok)
	);

	// Token queue decoupling the front from the frame engine.
	sfd_fifo #(
		.WIDTH ($bits(tok_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_tok_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fr_tok_valid),
		.wdata  (fr_tok),
		.pop    (bk_tok_pop),
		.rdata  (mid_tok),
		.full   (mid_full),
		.empty  (mid_empty)
	);

	// Back: frame engine.
	sfd_back #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fcs_disabled (fcs_disabled_q),
		.tok_valid    (!mid_empty),
		.tok          (mid_tok),
		.tok_pop      (bk_tok_pop),
		.res_full     (out_full),
		.res_push     (bk_res_push),
		.res          (bk_res)
	);

	// Result queue: holds finished beats so the engine keeps running while the
	// consumer stalls, until the queue fills.
	sfd_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (bk_res_push),
		.wdata  (bk_res),
		.pop    (pop),
		.rdata  (out_res),
		.full   (out_full),
		.empty  (empty)
	);

	assign data_byte    = out_res.data_byte;
	assign frame_last   = out_res.frame_last;
	assign frame_status = out_res.frame_status;
	assign frame_length = out_res.frame_length;

endmodule
